FILE: sv/link_connect_retry_supervisor_unit_assert.svh
// ----------------------------------------------------------------------------
// Link connect retry supervisor: assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LINK_CONNECT_RETRY_SUPERVISOR_UNIT_ASSERT_SVH
`define LINK_CONNECT_RETRY_SUPERVISOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LCRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LCRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lcrs_pkg.sv
// ----------------------------------------------------------------------------
// Link connect retry supervisor package
// Widths, event/state/error codes, register defaults and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lcrs_pkg;

    // field widths
    localparam int FUNC_W     = 4;
    localparam int TIME_W     = 32;
    localparam int ERR_W      = 4;
    localparam int STATE_W    = 4;
    localparam int REASON_W   = 3;
    localparam int CNT_W      = 8;
    localparam int SIG_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // event codes
    localparam logic [FUNC_W-1:0] FN_BOOT       = 4'd0;
    localparam logic [FUNC_W-1:0] FN_TAKE       = 4'd1;
    localparam logic [FUNC_W-1:0] FN_CONNECTING = 4'd2;
    localparam logic [FUNC_W-1:0] FN_ASSOC      = 4'd3;
    localparam logic [FUNC_W-1:0] FN_IP_READY   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_OFFLINE    = 4'd5;
    localparam logic [FUNC_W-1:0] FN_FAILURE    = 4'd6;
    localparam logic [FUNC_W-1:0] FN_TICK       = 4'd7;
    localparam logic [FUNC_W-1:0] FN_MANUAL     = 4'd8;
    localparam logic [FUNC_W-1:0] FN_CLEAR_ERR  = 4'd9;
    localparam logic [FUNC_W-1:0] FN_RESET      = 4'd10;

    // link states
    localparam logic [STATE_W-1:0] ST_IDLE       = 4'd0;
    localparam logic [STATE_W-1:0] ST_BOOTCHECK  = 4'd1;
    localparam logic [STATE_W-1:0] ST_PROVISION  = 4'd2;
    localparam logic [STATE_W-1:0] ST_REQUESTED  = 4'd3;
    localparam logic [STATE_W-1:0] ST_CONNECTING = 4'd4;
    localparam logic [STATE_W-1:0] ST_WAITIP     = 4'd5;
    localparam logic [STATE_W-1:0] ST_READY      = 4'd6;
    localparam logic [STATE_W-1:0] ST_RETRYWAIT  = 4'd7;
    localparam logic [STATE_W-1:0] ST_OFFLINE    = 4'd8;
    localparam logic [STATE_W-1:0] ST_ERROR      = 4'd9;

    // connect reasons
    localparam logic [REASON_W-1:0] RS_NONE   = 3'd0;
    localparam logic [REASON_W-1:0] RS_BOOT   = 3'd1;
    localparam logic [REASON_W-1:0] RS_RETRY  = 3'd2;
    localparam logic [REASON_W-1:0] RS_MANUAL = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ER_NONE     = 4'd0;
    localparam logic [ERR_W-1:0] ER_CREDS    = 4'd1;
    localparam logic [ERR_W-1:0] ER_SSID     = 4'd2;
    localparam logic [ERR_W-1:0] ER_NOTFOUND = 4'd3;
    localparam logic [ERR_W-1:0] ER_AUTH     = 4'd4;
    localparam logic [ERR_W-1:0] ER_DHCP     = 4'd5;
    localparam logic [ERR_W-1:0] ER_TIMEOUT  = 4'd6;
    localparam logic [ERR_W-1:0] ER_DRIVER   = 4'd7;
    localparam logic [ERR_W-1:0] ER_INTERNAL = 4'd8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_EN   = 3'd4;

    // register defaults
    localparam logic [CNT_W-1:0]  DEF_MAX_ATTEMPTS = 8'd3;
    localparam logic [TIME_W-1:0] DEF_TIMEOUT      = 32'd15000;
    localparam logic [TIME_W-1:0] DEF_BASE_DELAY   = 32'd1500;
    localparam logic [TIME_W-1:0] DEF_MAX_DELAY    = 32'd6000;
    localparam logic              DEF_BACKOFF_EN   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input request
        logic exec;      // apply the event to the link state
        logic bo_step;   // one backoff iteration
        logic out_load;  // load the result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic bo_needed; // event schedules a retry, delay must be computed
        logic bo_done;   // backoff iteration finishes this cycle
    } status_t;

    // not-found, dhcp, timeout and driver failures are retried
    function automatic logic is_retryable(input logic [ERR_W-1:0] e);
        logic r;
        case (e) inside
            ER_NOTFOUND, ER_DHCP, ER_TIMEOUT, ER_DRIVER: r = 1'b1;
            default:                                     r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/lcrs_ctrl.sv
// ----------------------------------------------------------------------------
// Link connect retry supervisor: controller
// Sequences capture, update, backoff iterations and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire lcrs_pkg::status_t status,
    output lcrs_pkg::cmd_t        cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_BACKOFF,
        S_FINISH
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = status.bo_needed ? S_BACKOFF : S_FINISH;
            end
            S_BACKOFF: begin
                cmd.bo_step = 1'b1;
                if (status.bo_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                // result register free or being emptied this cycle
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

FILE: sv/lcrs_dp.sv
// ----------------------------------------------------------------------------
// Link connect retry supervisor: datapath
// Configuration, link state registers, event update, iterative backoff
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrs_dp (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire lcrs_pkg::cmd_t                          cmd,
    output lcrs_pkg::status_t                            status,
    // configuration
    input  wire logic                                    cfg_we,
    input  wire logic        [lcrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [lcrs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // request fields
    input  wire logic        [lcrs_pkg::FUNC_W-1:0]      s_func,
    input  wire logic        [lcrs_pkg::TIME_W-1:0]      s_now_ms,
    input  wire logic                                    s_setup_done,
    input  wire logic                                    s_creds_present,
    input  wire logic                                    s_ssid_present,
    input  wire logic                                    s_addr_present,
    input  wire logic        [lcrs_pkg::ERR_W-1:0]       s_error_code,
    input  wire logic signed [lcrs_pkg::SIG_W-1:0]       s_signal_dbm,
    // result fields
    output logic             [lcrs_pkg::STATE_W-1:0]     m_link_state,
    output logic             [lcrs_pkg::REASON_W-1:0]    m_connect_reason,
    output logic             [lcrs_pkg::ERR_W-1:0]       m_last_error,
    output logic                                         m_needs_provisioning,
    output logic                                         m_ack_flag,
    output logic                                         m_is_ready,
    output logic                                         m_is_connecting,
    output logic                                         m_is_terminal,
    output logic             [lcrs_pkg::CNT_W-1:0]       m_attempt_count,
    output logic             [lcrs_pkg::TIME_W-1:0]      m_retry_due,
    output logic             [lcrs_pkg::TIME_W-1:0]      m_change_count,
    output logic signed      [lcrs_pkg::SIG_W-1:0]       m_signal_level
);

    localparam int TW = lcrs_pkg::TIME_W;

    // captured request
    logic [lcrs_pkg::FUNC_W-1:0]        in_func_reg;
    logic [TW-1:0]                      in_now_reg;
    logic                               in_setup_reg, in_creds_reg, in_ssid_reg, in_addr_reg;
    logic [lcrs_pkg::ERR_W-1:0]         in_err_reg;
    logic signed [lcrs_pkg::SIG_W-1:0]  in_sig_reg;

    // configuration
    logic [lcrs_pkg::CNT_W-1:0] max_att_reg;
    logic [TW-1:0]              timeout_reg, base_reg, maxd_reg;
    logic                       bo_en_reg;

    // link state
    logic [lcrs_pkg::STATE_W-1:0]      state_reg, state_next;
    logic [lcrs_pkg::REASON_W-1:0]     reason_reg, reason_next;
    logic [lcrs_pkg::ERR_W-1:0]        err_reg, err_next;
    logic                              pending_reg, pending_next;
    logic                              addr_valid_reg, addr_valid_next;
    logic                              prov_reg, prov_next;
    logic                              creds_reg, creds_next;
    logic                              ssid_reg, ssid_next;
    logic [lcrs_pkg::CNT_W-1:0]        attempt_reg, attempt_next;
    logic [TW-1:0]                     start_reg, start_next;
    logic [TW-1:0]                     due_reg, due_next;
    logic [TW-1:0]                     gen_reg, gen_next;
    logic signed [lcrs_pkg::SIG_W-1:0] rssi_reg, rssi_next;
    logic                              ack_reg, ack_next;

    // backoff unit
    logic [TW-1:0]              bo_d_reg;
    logic [lcrs_pkg::CNT_W-1:0] bo_rem_reg;
    logic                       bo_clamp_reg;
    logic [TW-1:0]              bo_result;
    logic                       bo_done;

    // result register
    logic [lcrs_pkg::STATE_W-1:0]      o_state_reg;
    logic [lcrs_pkg::REASON_W-1:0]     o_reason_reg;
    logic [lcrs_pkg::ERR_W-1:0]        o_err_reg;
    logic                              o_prov_reg, o_ack_reg, o_ready_reg;
    logic                              o_conn_reg, o_term_reg;
    logic [lcrs_pkg::CNT_W-1:0]        o_attempt_reg;
    logic [TW-1:0]                     o_due_reg, o_gen_reg;
    logic signed [lcrs_pkg::SIG_W-1:0] o_rssi_reg;

    // event decode helpers
    logic [lcrs_pkg::ERR_W-1:0]    err_sat, fail_err;
    logic [TW-1:0]                 elapsed, since_due;
    logic                          timeout_hit, retry_fire;
    logic                          do_start, do_fail;
    logic [lcrs_pkg::REASON_W-1:0] start_reason;
    logic [1:0]                    gen_add;

    assign err_sat   = (in_err_reg > lcrs_pkg::ER_INTERNAL) ? lcrs_pkg::ER_INTERNAL
                                                            : in_err_reg;
    assign elapsed   = in_now_reg - start_reg;
    assign since_due = in_now_reg - due_reg;

    assign timeout_hit = ((state_reg == lcrs_pkg::ST_CONNECTING) ||
                          (state_reg == lcrs_pkg::ST_WAITIP)) &&
                         (timeout_reg != '0) && (elapsed >= timeout_reg);
    assign retry_fire  = (state_reg == lcrs_pkg::ST_RETRYWAIT) && !since_due[TW-1];

    // event update
    always_comb begin
        state_next      = state_reg;
        reason_next     = reason_reg;
        err_next        = err_reg;
        pending_next    = pending_reg;
        addr_valid_next = addr_valid_reg;
        prov_next       = prov_reg;
        creds_next      = creds_reg;
        ssid_next       = ssid_reg;
        attempt_next    = attempt_reg;
        start_next      = start_reg;
        due_next        = due_reg;
        rssi_next       = rssi_reg;
        ack_next        = 1'b0;
        gen_add         = 2'd0;
        do_start        = 1'b0;
        do_fail         = 1'b0;
        start_reason    = lcrs_pkg::RS_NONE;
        fail_err        = err_sat;

        unique case (in_func_reg)
            lcrs_pkg::FN_BOOT: begin
                state_next      = lcrs_pkg::ST_BOOTCHECK;
                reason_next     = lcrs_pkg::RS_BOOT;
                err_next        = lcrs_pkg::ER_NONE;
                pending_next    = 1'b0;
                addr_valid_next = 1'b0;
                prov_next       = 1'b0;
                creds_next      = in_creds_reg;
                ssid_next       = in_ssid_reg;
                attempt_next    = '0;
                start_next      = '0;
                due_next        = '0;
                rssi_next       = '0;
                gen_add         = 2'd1;
                if (!in_setup_reg || !in_creds_reg) begin
                    err_next   = lcrs_pkg::ER_CREDS;
                    prov_next  = 1'b1;
                    state_next = lcrs_pkg::ST_PROVISION;
                end else if (!in_ssid_reg) begin
                    err_next   = lcrs_pkg::ER_SSID;
                    prov_next  = 1'b1;
                    state_next = lcrs_pkg::ST_PROVISION;
                end else begin
                    attempt_next = 8'd1;
                    do_start     = 1'b1;
                    start_reason = lcrs_pkg::RS_BOOT;
                    ack_next     = 1'b1;
                end
            end
            lcrs_pkg::FN_TAKE: begin
                ack_next     = pending_reg;
                pending_next = 1'b0;
            end
            lcrs_pkg::FN_CONNECTING: begin
                addr_valid_next = 1'b0;
                rssi_next       = '0;
                pending_next    = 1'b0;
                start_next      = in_now_reg;
                err_next        = lcrs_pkg::ER_NONE;
                state_next      = lcrs_pkg::ST_CONNECTING;
                gen_add         = 2'd1;
            end
            lcrs_pkg::FN_ASSOC: begin
                addr_valid_next = 1'b0;
                rssi_next       = in_sig_reg;
                err_next        = lcrs_pkg::ER_NONE;
                state_next      = lcrs_pkg::ST_WAITIP;
                gen_add         = 2'd1;
            end
            lcrs_pkg::FN_IP_READY: begin
                addr_valid_next = in_addr_reg;
                rssi_next       = in_sig_reg;
                pending_next    = 1'b0;
                prov_next       = 1'b0;
                due_next        = '0;
                err_next        = in_addr_reg ? lcrs_pkg::ER_NONE : lcrs_pkg::ER_DHCP;
                state_next      = in_addr_reg ? lcrs_pkg::ST_READY : lcrs_pkg::ST_ERROR;
                gen_add         = 2'd1;
            end
            lcrs_pkg::FN_OFFLINE: begin
                addr_valid_next = 1'b0;
                rssi_next       = '0;
                pending_next    = 1'b0;
                err_next        = err_sat;
                state_next      = lcrs_pkg::ST_OFFLINE;
                prov_next       = 1'b0;
                gen_add         = 2'd1;
            end
            lcrs_pkg::FN_FAILURE: begin
                do_fail = 1'b1;
            end
            lcrs_pkg::FN_TICK: begin
                // connect timeout takes precedence over the retry deadline
                if (timeout_hit) begin
                    do_fail  = 1'b1;
                    fail_err = lcrs_pkg::ER_TIMEOUT;
                end else if (retry_fire) begin
                    attempt_next = attempt_reg + 8'd1;
                    do_start     = 1'b1;
                    start_reason = lcrs_pkg::RS_RETRY;
                end
            end
            lcrs_pkg::FN_MANUAL: begin
                if (!creds_reg || !ssid_reg) begin
                    err_next   = lcrs_pkg::ER_CREDS;
                    prov_next  = 1'b1;
                    state_next = lcrs_pkg::ST_PROVISION;
                    gen_add    = 2'd1;
                end else begin
                    attempt_next = 8'd1;
                    do_start     = 1'b1;
                    start_reason = lcrs_pkg::RS_MANUAL;
                end
            end
            lcrs_pkg::FN_CLEAR_ERR: begin
                err_next = lcrs_pkg::ER_NONE;
                if (state_reg == lcrs_pkg::ST_ERROR) begin
                    state_next = lcrs_pkg::ST_IDLE;
                end
                gen_add = 2'd1;
            end
            lcrs_pkg::FN_RESET: begin
                // all link state back to reset values except the change counter
                state_next      = lcrs_pkg::ST_IDLE;
                reason_next     = lcrs_pkg::RS_NONE;
                err_next        = lcrs_pkg::ER_NONE;
                pending_next    = 1'b0;
                addr_valid_next = 1'b0;
                prov_next       = 1'b0;
                creds_next      = 1'b0;
                ssid_next       = 1'b0;
                attempt_next    = '0;
                start_next      = '0;
                due_next        = '0;
                rssi_next       = '0;
            end
            default: ;
        endcase

        // issue a connect request
        if (do_start) begin
            reason_next     = start_reason;
            err_next        = lcrs_pkg::ER_NONE;
            pending_next    = 1'b1;
            addr_valid_next = 1'b0;
            start_next      = in_now_reg;
            due_next        = '0;
            state_next      = lcrs_pkg::ST_REQUESTED;
            gen_add         = gen_add + 2'd1;
        end

        // sort a failure; the retry deadline is filled in by the backoff unit
        if (do_fail) begin
            addr_valid_next = 1'b0;
            rssi_next       = '0;
            pending_next    = 1'b0;
            err_next        = fail_err;
            gen_add         = 2'd1;
            if (fail_err == lcrs_pkg::ER_AUTH) begin
                state_next = lcrs_pkg::ST_OFFLINE;
                prov_next  = 1'b0;
            end else if (!lcrs_pkg::is_retryable(fail_err)) begin
                state_next = lcrs_pkg::ST_ERROR;
            end else if (attempt_reg >= max_att_reg) begin
                state_next = lcrs_pkg::ST_OFFLINE;
                prov_next  = 1'b0;
            end else begin
                state_next = lcrs_pkg::ST_RETRYWAIT;
            end
        end

        gen_next = gen_reg + TW'(gen_add);
    end

    assign status.bo_needed = do_fail && lcrs_pkg::is_retryable(fail_err) &&
                              (attempt_reg < max_att_reg);

    // backoff iteration: one doubling per cycle until the attempts run out, early exit at the ceiling or at zero
    always_comb begin
        bo_done   = 1'b0;
        bo_result = bo_d_reg;
        if (bo_rem_reg == '0) begin
            bo_done   = 1'b1;
            bo_result = (bo_clamp_reg && (bo_d_reg > maxd_reg)) ? maxd_reg : bo_d_reg;
        end else if ((bo_d_reg >= maxd_reg) || (bo_d_reg > (maxd_reg >> 1))) begin
            bo_done   = 1'b1;
            bo_result = maxd_reg;
        end else if (bo_d_reg == '0) begin
            // zero never grows
            bo_done   = 1'b1;
            bo_result = '0;
        end
    end

    assign status.bo_done = bo_done;

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_att_reg    <= lcrs_pkg::DEF_MAX_ATTEMPTS;
            timeout_reg    <= lcrs_pkg::DEF_TIMEOUT;
            base_reg       <= lcrs_pkg::DEF_BASE_DELAY;
            maxd_reg       <= lcrs_pkg::DEF_MAX_DELAY;
            bo_en_reg      <= lcrs_pkg::DEF_BACKOFF_EN;
            state_reg      <= lcrs_pkg::ST_IDLE;
            reason_reg     <= lcrs_pkg::RS_NONE;
            err_reg        <= lcrs_pkg::ER_NONE;
            pending_reg    <= 1'b0;
            addr_valid_reg <= 1'b0;
            prov_reg       <= 1'b0;
            creds_reg      <= 1'b0;
            ssid_reg       <= 1'b0;
            attempt_reg    <= '0;
            start_reg      <= '0;
            due_reg        <= '0;
            gen_reg        <= '0;
            rssi_reg       <= '0;
            ack_reg        <= 1'b0;
            bo_rem_reg     <= '0;
            bo_clamp_reg   <= 1'b0;
        end else begin
            // configuration writes
            if (cfg_we) begin
                unique case (cfg_index)
                    lcrs_pkg::CFG_MAX_ATTEMPTS: max_att_reg <= cfg_wdata[lcrs_pkg::CNT_W-1:0];
                    lcrs_pkg::CFG_TIMEOUT:      timeout_reg <= cfg_wdata[TW-1:0];
                    lcrs_pkg::CFG_BASE_DELAY:   base_reg    <= cfg_wdata[TW-1:0];
                    lcrs_pkg::CFG_MAX_DELAY:    maxd_reg    <= cfg_wdata[TW-1:0];
                    lcrs_pkg::CFG_BACKOFF_EN:   bo_en_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (cmd.exec) begin
                state_reg      <= state_next;
                reason_reg     <= reason_next;
                err_reg        <= err_next;
                pending_reg    <= pending_next;
                addr_valid_reg <= addr_valid_next;
                prov_reg       <= prov_next;
                creds_reg      <= creds_next;
                ssid_reg       <= ssid_next;
                attempt_reg    <= attempt_next;
                start_reg      <= start_next;
                due_reg        <= due_next;
                gen_reg        <= gen_next;
                rssi_reg       <= rssi_next;
                ack_reg        <= ack_next;
                // backoff setup from the attempt number before the update
                if (!bo_en_reg || (attempt_reg <= 8'd1)) begin
                    bo_rem_reg   <= '0;
                    bo_clamp_reg <= 1'b0;
                end else begin
                    bo_rem_reg   <= attempt_reg - 8'd1;
                    bo_clamp_reg <= 1'b1;
                end
            end else if (cmd.bo_step) begin
                if (bo_done) begin
                    due_reg <= in_now_reg + bo_result;
                end else begin
                    bo_rem_reg <= bo_rem_reg - 8'd1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_func_reg  <= s_func;
            in_now_reg   <= s_now_ms;
            in_setup_reg <= s_setup_done;
            in_creds_reg <= s_creds_present;
            in_ssid_reg  <= s_ssid_present;
            in_addr_reg  <= s_addr_present;
            in_err_reg   <= s_error_code;
            in_sig_reg   <= s_signal_dbm;
        end
        if (cmd.exec) begin
            bo_d_reg <= base_reg;
        end else if (cmd.bo_step && !bo_done) begin
            bo_d_reg <= bo_d_reg << 1;
        end
        if (cmd.out_load) begin
            o_state_reg   <= state_reg;
            o_reason_reg  <= reason_reg;
            o_err_reg     <= err_reg;
            o_prov_reg    <= prov_reg;
            o_ack_reg     <= ack_reg;
            o_ready_reg   <= (state_reg == lcrs_pkg::ST_READY) && addr_valid_reg;
            o_conn_reg    <= (state_reg == lcrs_pkg::ST_REQUESTED) ||
                             (state_reg == lcrs_pkg::ST_CONNECTING) ||
                             (state_reg == lcrs_pkg::ST_WAITIP) ||
                             (state_reg == lcrs_pkg::ST_RETRYWAIT);
            o_term_reg    <= (state_reg == lcrs_pkg::ST_ERROR) ||
                             (state_reg == lcrs_pkg::ST_OFFLINE);
            o_attempt_reg <= attempt_reg;
            o_due_reg     <= due_reg;
            o_gen_reg     <= gen_reg;
            o_rssi_reg    <= rssi_reg;
        end
    end

    assign m_link_state         = o_state_reg;
    assign m_connect_reason     = o_reason_reg;
    assign m_last_error         = o_err_reg;
    assign m_needs_provisioning = o_prov_reg;
    assign m_ack_flag           = o_ack_reg;
    assign m_is_ready           = o_ready_reg;
    assign m_is_connecting      = o_conn_reg;
    assign m_is_terminal        = o_term_reg;
    assign m_attempt_count      = o_attempt_reg;
    assign m_retry_due          = o_due_reg;
    assign m_change_count       = o_gen_reg;
    assign m_signal_level       = o_rssi_reg;

endmodule

`default_nettype wire

FILE: sv/link_connect_retry_supervisor_unit.sv
// ----------------------------------------------------------------------------
// Link connect retry supervisor
// Tracks link state, errors and retries with exponential backoff.
// ----------------------------------------------------------------------------
// One request carries one link event and yields exactly one result with the
// link status after that event. A request's result is valid after the state
// update and then the result load, once the result register is free. A
// failure that schedules a retry adds backoff iterations: the backoff
// unit doubles the retry delay once per cycle until it reaches the ceiling
// or runs out of attempts, or at once if the delay is zero. The next request
// is accepted while an earlier result still waits to be taken; its own
// result is loaded once the register frees up. Configuration writes take
// effect at once; the user makes them while no request is in flight, which the block does not enforce.
`default_nettype none

module link_connect_retry_supervisor_unit (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // configuration
    input  wire logic                                    cfg_we,
    input  wire logic        [lcrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [lcrs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // event requests
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic        [lcrs_pkg::FUNC_W-1:0]      s_func,
    input  wire logic        [lcrs_pkg::TIME_W-1:0]      s_now_ms,
    input  wire logic                                    s_setup_done,
    input  wire logic                                    s_creds_present,
    input  wire logic                                    s_ssid_present,
    input  wire logic                                    s_addr_present,
    input  wire logic        [lcrs_pkg::ERR_W-1:0]       s_error_code,
    input  wire logic signed [lcrs_pkg::SIG_W-1:0]       s_signal_dbm,
    // status results
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic             [lcrs_pkg::STATE_W-1:0]     m_link_state,
    output logic             [lcrs_pkg::REASON_W-1:0]    m_connect_reason,
    output logic             [lcrs_pkg::ERR_W-1:0]       m_last_error,
    output logic                                         m_needs_provisioning,
    output logic                                         m_ack_flag,
    output logic                                         m_is_ready,
    output logic                                         m_is_connecting,
    output logic                                         m_is_terminal,
    output logic             [lcrs_pkg::CNT_W-1:0]       m_attempt_count,
    output logic             [lcrs_pkg::TIME_W-1:0]      m_retry_due,
    output logic             [lcrs_pkg::TIME_W-1:0]      m_change_count,
    output logic signed      [lcrs_pkg::SIG_W-1:0]       m_signal_level
);

    lcrs_pkg::cmd_t    cmd;
    lcrs_pkg::status_t status;

    // sequencing
    lcrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // state, backoff and result
    lcrs_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_func               (s_func),
        .s_now_ms             (s_now_ms),
        .s_setup_done         (s_setup_done),
        .s_creds_present      (s_creds_present),
        .s_ssid_present       (s_ssid_present),
        .s_addr_present       (s_addr_present),
        .s_error_code         (s_error_code),
        .s_signal_dbm         (s_signal_dbm),
        .m_link_state         (m_link_state),
        .m_connect_reason     (m_connect_reason),
        .m_last_error         (m_last_error),
        .m_needs_provisioning (m_needs_provisioning),
        .m_ack_flag           (m_ack_flag),
        .m_is_ready           (m_is_ready),
        .m_is_connecting      (m_is_connecting),
        .m_is_terminal        (m_is_terminal),
        .m_attempt_count      (m_attempt_count),
        .m_retry_due          (m_retry_due),
        .m_change_count       (m_change_count),
        .m_signal_level       (m_signal_level)
    );

endmodule

`default_nettype wire

FILE: sv/lcrs_checker.sv
// ----------------------------------------------------------------------------
// Link connect retry supervisor: port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "link_connect_retry_supervisor_unit_assert.svh"

module lcrs_checker (
    input wire logic                                    aclk,
    input wire logic                                    aresetn,
    input wire logic                                    s_valid,
    input wire logic                                    s_ready,
    input wire logic                                    m_valid,
    input wire logic                                    m_ready,
    input wire logic        [lcrs_pkg::STATE_W-1:0]     m_link_state,
    input wire logic                                    m_is_ready,
    input wire logic                                    m_is_terminal,
    input wire logic        [lcrs_pkg::TIME_W-1:0]      m_retry_due,
    input wire logic        [lcrs_pkg::TIME_W-1:0]      m_change_count
);

    // a stalled result holds
    `LCRS_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_link_state) && $stable(m_change_count) && $stable(m_retry_due), "stalled result changed")

    // one request in flight: no acceptance right after one
    `LCRS_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "request accepted back to back")

    // ready flag only in the ready state
    `LCRS_ASSERT_NOW(a_ready_state, m_valid && m_is_ready, m_link_state == lcrs_pkg::ST_READY, "ready flag outside ready state")

    // terminal flag matches the error and offline states
    `LCRS_ASSERT_NOW(a_terminal_state, m_valid, m_is_terminal == ((m_link_state == lcrs_pkg::ST_ERROR) || (m_link_state == lcrs_pkg::ST_OFFLINE)), "terminal flag mismatch")

endmodule

bind link_connect_retry_supervisor_unit lcrs_checker u_lcrs_checker (.*);

`default_nettype wire
